// ----- rtl/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg: shared types and helpers for the string intern table
// Holds table sizes, controller state and command types, the CRC-16/KERMIT
// byte step and the hex digit table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int STORE_LEN     = 12;
  localparam int ENTRY_AW      = 6;
  localparam int CHAR_AW       = 4;
  localparam int TEXT_AW       = ENTRY_AW + CHAR_AW;
  localparam int CNT_W         = 7;
  localparam int TRY_W         = 17;
  localparam logic [3:0] TEMP_NAME_LEN = 4'd8;

  typedef enum logic [1:0] {
    FUNC_INTERN = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_TEMP   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_INTERN,
    OP_LOOKUP,
    OP_TEMP
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIN,
    ST_TMP_INC,
    ST_TMP_CRC,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_WR_TXT,
    ST_LK_RD,
    ST_LK_EMIT,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_char;
    logic accept_last;
    logic load_query;
    logic start_temp;
    logic temp_mode;
    logic tmp_inc;
    logic tmp_crc_step;
    logic clr_idx;
    logic inc_idx;
    logic meta_rd;
    logic capture_len;
    logic clr_k;
    logic inc_k;
    logic text_rd;
    logic wr_meta;
    logic wr_text;
    logic inc_count;
    logic set_res;
    logic res_zero;
    logic res_full;
    logic out_load_res;
    logic out_load_char;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_at_count;
    logic tbl_full;
    logic id_match;
    logic len_match;
    logic k_at_len;
    logic k_at_name;
    logic text_match;
    logic key_crc_zero;
    logic key_long;
    logic res_is_zero;
    logic res_full;
    logic tries_done;
    logic out_free;
    logic lk_last;
  } stat_t;

  // one byte of CRC-16/KERMIT (reflected 0x8408, init 0)
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ c[7:0];
    d = d ^ {d[3:0], 4'b0};
    return {d, c[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b0};
  endfunction

  // upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    case (n)
      4'd0:  r = 8'h30;
      4'd1:  r = 8'h31;
      4'd2:  r = 8'h32;
      4'd3:  r = 8'h33;
      4'd4:  r = 8'h34;
      4'd5:  r = 8'h35;
      4'd6:  r = 8'h36;
      4'd7:  r = 8'h37;
      4'd8:  r = 8'h38;
      4'd9:  r = 8'h39;
      4'd10: r = 8'h41;
      4'd11: r = 8'h42;
      4'd12: r = 8'h43;
      4'd13: r = 8'h44;
      4'd14: r = 8'h45;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/string_intern_table_crc16_unit.sv -----
// Operation: a non-final character is taken while idle; a string end or lookup walks the
//   stored ids one entry at a time (up to 64), compares or writes text one character at a time,
//   and transfers a lookup hit one character at a time, waiting while the output is stalled.
// A temporary name bumps its counter and hashes its name, then walks the table per attempt, retried on id 0.
// One item is in work at a time; the single-port table memories set the rate.
// Reset (rst_n, synchronous low) empties the table and pending string; no clear pass.
// ----------------------------------------------------------------------------
// string_intern_table_crc16_unit: string intern table top level
// Joins the sequencer and the datapath to the input and result streams.
// ----------------------------------------------------------------------------
module string_intern_table_crc16_unit import sit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // char_byte[7:0], query_id[15:0]
  input  logic [1:0]  in_tuser,    // func[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // result_id[15:0], found, text_char[7:0], table_count[6:0], table_full
  output logic        out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  sit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .in_last   (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  sit_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (in_tdata[7:0]),
    .in_query   (in_tdata[23:8]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // found goes with a nonzero id
  a_found_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16] == (out_tdata[15:0] != 16'd0)))
    else $error("found flag disagrees with id");

  // a full report only comes with id 0 and a full table
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[15:0] == 16'd0 && out_tdata[31:25] == 7'd64))
    else $error("table full reported without full table");

  // never insert into a full table
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_meta |-> !stat.tbl_full)
    else $error("insert into full table");

endmodule

// ----- rtl/sit_ctrl.sv -----
// ----------------------------------------------------------------------------
// sit_ctrl: operation sequencer
// Steps intern, lookup and temporary-name operations through table search,
// text compare, insert and result transfer.
// ----------------------------------------------------------------------------
module sit_ctrl import sit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_func,
  input  logic       in_last,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // state and operation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_INTERN;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd           = '0;
    cmd.temp_mode = (op_r == OP_TEMP);
    in_tready     = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (func_t'(in_func))
            FUNC_INTERN: begin
              cmd.accept_char = 1'b1;
              if (in_last) begin
                cmd.accept_last = 1'b1;
                op_nxt          = OP_INTERN;
                state_nxt       = ST_FIN;
              end
            end
            FUNC_LOOKUP: begin
              cmd.load_query = 1'b1;
              cmd.clr_idx    = 1'b1;
              op_nxt         = OP_LOOKUP;
              state_nxt      = ST_SRCH_RD;
            end
            FUNC_TEMP: begin
              cmd.start_temp = 1'b1;
              op_nxt         = OP_TEMP;
              state_nxt      = ST_TMP_INC;
            end
            default: ;
          endcase
        end
      end
      ST_TMP_INC: begin
        cmd.tmp_inc = 1'b1;
        state_nxt   = ST_TMP_CRC;
      end
      ST_TMP_CRC: begin
        if (stat.k_at_name) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.tmp_crc_step = 1'b1;
          cmd.inc_k        = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat.key_long || stat.key_crc_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_zero = 1'b1;
          state_nxt    = ST_DECIDE;
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt   = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (stat.idx_at_count) begin
          // no entry with this id
          if (op_r == OP_LOOKUP || stat.tbl_full) begin
            cmd.set_res  = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_full = (op_r != OP_LOOKUP);
            state_nxt    = ST_DECIDE;
          end else begin
            cmd.wr_meta = 1'b1;
            cmd.clr_k   = 1'b1;
            state_nxt   = ST_WR_TXT;
          end
        end else begin
          cmd.meta_rd = 1'b1;
          state_nxt   = ST_SRCH_CHK;
        end
      end
      ST_SRCH_CHK: begin
        if (stat.id_match) begin
          cmd.clr_k = 1'b1;
          if (op_r == OP_LOOKUP) begin
            cmd.capture_len = 1'b1;
            state_nxt       = ST_LK_RD;
          end else if (stat.len_match) begin
            state_nxt = ST_CMP_RD;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_zero = 1'b1;
            state_nxt    = ST_DECIDE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = ST_SRCH_RD;
        end
      end
      ST_CMP_RD: begin
        if (stat.k_at_len) begin
          cmd.set_res = 1'b1;
          state_nxt   = ST_DECIDE;
        end else begin
          cmd.text_rd = 1'b1;
          state_nxt   = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        if (stat.text_match) begin
          cmd.inc_k = 1'b1;
          state_nxt = ST_CMP_RD;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_zero = 1'b1;
          state_nxt    = ST_DECIDE;
        end
      end
      ST_WR_TXT: begin
        if (stat.k_at_len) begin
          cmd.inc_count = 1'b1;
          cmd.set_res   = 1'b1;
          state_nxt     = ST_DECIDE;
        end else begin
          cmd.wr_text = 1'b1;
          cmd.inc_k   = 1'b1;
        end
      end
      ST_LK_RD: begin
        cmd.text_rd = 1'b1;
        state_nxt   = ST_LK_EMIT;
      end
      ST_LK_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load_char = 1'b1;
          if (stat.lk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.inc_k = 1'b1;
            state_nxt = ST_LK_RD;
          end
        end
      end
      ST_DECIDE: begin
        // retry a temporary name that got no id
        if (op_r == OP_TEMP && stat.res_is_zero && !stat.res_full && !stat.tries_done) begin
          state_nxt = ST_TMP_INC;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load_res = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/sit_dpath.sv -----
// ----------------------------------------------------------------------------
// sit_dpath: intern table datapath
// Pending string, key and CRC registers, the entry id, length and text
// memories, and the output register.
// ----------------------------------------------------------------------------
module sit_dpath import sit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  in_char,
  input  logic [15:0] in_query,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // id[15:0], found, text_char[7:0], count[6:0], full
  output logic        out_tlast
);

  // memories
  logic [15:0] ids_mem  [TABLE_ENTRIES];
  logic [3:0]  len_mem  [TABLE_ENTRIES];
  logic [7:0]  text_mem [2**TEXT_AW];
  logic [7:0]  pend_r   [STORE_LEN];

  logic [3:0]       pend_len_r;
  logic             pend_long_r;
  logic [15:0]      run_crc_r;
  logic [15:0]      key_crc_r;
  logic [3:0]       key_len_r;
  logic             key_long_r;
  logic [15:0]      tcnt_r;
  logic [TRY_W-1:0] tries_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic [3:0]       k_r;
  logic [15:0]      rd_id_r;
  logic [3:0]       rd_len_r;
  logic [7:0]       rd_text_r;
  logic [15:0]      res_id_r;
  logic             res_full_r;
  logic             out_valid_r;
  logic [39:0]      out_data_r;
  logic             out_last_r;

  logic [15:0] crc_nxt;
  logic        pend_room;
  logic [7:0]  key_char;
  logic [7:0]  name_char;
  logic        out_free;

  assign pend_room = (pend_len_r < 4'(STORE_LEN));
  assign crc_nxt   = crc_step(run_crc_r, in_char);
  assign out_free  = !out_valid_r || out_tready;

  // character k of the temporary name
  always_comb begin
    case (k_r)
      4'd0:    name_char = 8'h54;
      4'd1:    name_char = 8'h45;
      4'd2:    name_char = 8'h4D;
      4'd3:    name_char = 8'h50;
      4'd4:    name_char = hex_char(tcnt_r[15:12]);
      4'd5:    name_char = hex_char(tcnt_r[11:8]);
      4'd6:    name_char = hex_char(tcnt_r[7:4]);
      4'd7:    name_char = hex_char(tcnt_r[3:0]);
      default: name_char = 8'h00;
    endcase
  end

  // character k of the key string
  always_comb begin
    if (cmd.temp_mode) begin
      key_char = name_char;
    end else if (k_r < 4'(STORE_LEN)) begin
      key_char = pend_r[k_r];
    end else begin
      key_char = 8'h00;
    end
  end

  // pending string and running CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_len_r  <= '0;
      pend_long_r <= 1'b0;
      run_crc_r   <= '0;
    end else if (cmd.accept_char) begin
      if (cmd.accept_last) begin
        pend_len_r  <= '0;
        pend_long_r <= 1'b0;
        run_crc_r   <= '0;
      end else begin
        if (pend_room) pend_len_r <= pend_len_r + 4'd1;
        else           pend_long_r <= 1'b1;
        run_crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_char && pend_room) pend_r[pend_len_r] <= in_char;
  end

  // key, temporary counter and tries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcnt_r     <= '0;
      tries_r    <= '0;
      key_long_r <= 1'b0;
    end else begin
      if (cmd.accept_last) key_long_r <= pend_long_r || !pend_room;
      if (cmd.start_temp) begin
        key_long_r <= 1'b0;
        tries_r    <= '0;
      end
      if (cmd.tmp_inc) begin
        tcnt_r  <= tcnt_r + 16'd1;
        tries_r <= tries_r + TRY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_last) begin
      key_crc_r <= crc_nxt;
      key_len_r <= pend_room ? pend_len_r + 4'd1 : pend_len_r;
    end
    if (cmd.load_query) key_crc_r <= in_query;
    if (cmd.tmp_inc) begin
      key_crc_r <= '0;
      key_len_r <= TEMP_NAME_LEN;
    end
    if (cmd.tmp_crc_step) key_crc_r <= crc_step(key_crc_r, name_char);
    if (cmd.capture_len)  key_len_r <= rd_len_r;
  end

  // search index, char index and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.inc_count) count_r <= count_r + CNT_W'(1);
      if (cmd.clr_idx)   idx_r   <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + CNT_W'(1);
      if (cmd.clr_k || cmd.tmp_inc) k_r <= '0;
      else if (cmd.inc_k) k_r <= k_r + 4'd1;
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.wr_meta) begin
      ids_mem[count_r[ENTRY_AW-1:0]] <= key_crc_r;
      len_mem[count_r[ENTRY_AW-1:0]] <= key_len_r;
    end
    if (cmd.meta_rd) begin
      rd_id_r  <= ids_mem[idx_r[ENTRY_AW-1:0]];
      rd_len_r <= len_mem[idx_r[ENTRY_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_text) text_mem[{count_r[ENTRY_AW-1:0], k_r}] <= key_char;
    if (cmd.text_rd) rd_text_r <= text_mem[{idx_r[ENTRY_AW-1:0], k_r}];
  end

  // operation result
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_id_r   <= cmd.res_zero ? 16'd0 : key_crc_r;
      res_full_r <= cmd.res_full;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load_res || cmd.out_load_char) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_res) begin
      out_data_r <= {7'd0, res_full_r, count_r, 8'd0, (res_id_r != 16'd0), res_id_r};
      out_last_r <= 1'b1;
    end else if (cmd.out_load_char) begin
      out_data_r <= {7'd0, 1'b0, count_r, rd_text_r, 1'b1, key_crc_r};
      out_last_r <= (k_r + 4'd1 == key_len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // status
  always_comb begin
    stat              = '0;
    stat.idx_at_count = (idx_r == count_r);
    stat.tbl_full     = (count_r >= CNT_W'(TABLE_ENTRIES));
    stat.id_match     = (rd_id_r == key_crc_r);
    stat.len_match    = (rd_len_r == key_len_r);
    stat.k_at_len     = (k_r == key_len_r);
    stat.k_at_name    = (k_r == TEMP_NAME_LEN);
    stat.text_match   = (rd_text_r == key_char);
    stat.key_crc_zero = (key_crc_r == 16'd0);
    stat.key_long     = key_long_r;
    stat.res_is_zero  = (res_id_r == 16'd0);
    stat.res_full     = res_full_r;
    stat.tries_done   = tries_r[TRY_W-1];
    stat.out_free     = out_free;
    stat.lk_last      = (k_r + 4'd1 == key_len_r);
  end

endmodule
